>>> rtl/stable_sorted_priority_queue_defines.svh
// Assertion macros for the stable sorted priority queue checker.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SSPQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SSPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sspq_pkg.sv
// Shared constants, codes and control structs for the priority queue.
package sspq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int PAYLOAD_W   = 32;
	localparam int PRIO_W      = 7;
	localparam int ID_W        = 16;
	localparam int OCC_W       = 5;

	localparam logic [PRIO_W-1:0] PRIO_MIN = 7'd1;
	localparam logic [PRIO_W-1:0] PRIO_MAX = 7'd100;
	localparam logic [ID_W-1:0]   ID_FIRST = 16'd1;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;
		logic    exec;
		op_t     op;
		status_t code;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_remove;
		logic prio_ok;
		logic empty;
		logic full;
	} stat_t;

endpackage

>>> rtl/sspq_channels.sv
// Handshake channel interfaces for requests and responses.
interface sspq_cmd_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic [sspq_pkg::PRIO_W-1:0]        priority_req;
	logic [sspq_pkg::PAYLOAD_W-1:0]     payload;

	modport source (output valid, action, priority_req, payload, input ready);
	modport sink (input valid, action, priority_req, payload, output ready);
endinterface

interface sspq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         status;
	logic [sspq_pkg::ID_W-1:0]          entry_id;
	logic [sspq_pkg::PRIO_W-1:0]        entry_priority;
	logic [sspq_pkg::PAYLOAD_W-1:0]     entry_payload;
	logic [sspq_pkg::OCC_W-1:0]         occupancy;

	modport source (output valid, status, entry_id, entry_priority, entry_payload, occupancy,
		input ready);
	modport sink (input valid, status, entry_id, entry_priority, entry_payload, occupancy,
		output ready);
endinterface

>>> rtl/sspq_dp.sv
// Datapath: sorted cell array, counters, request latch and result register.
module sspq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sspq_pkg::cmd_t                  cmd,
	output sspq_pkg::stat_t                 stat,
	input  logic                            req_action,
	input  logic [sspq_pkg::PRIO_W-1:0]     req_priority,
	input  logic [sspq_pkg::PAYLOAD_W-1:0]  req_payload,
	output logic [1:0]                      res_status,
	output logic [sspq_pkg::ID_W-1:0]       res_id,
	output logic [sspq_pkg::PRIO_W-1:0]     res_priority,
	output logic [sspq_pkg::PAYLOAD_W-1:0]  res_payload,
	output logic [sspq_pkg::OCC_W-1:0]      res_occupancy
);

	logic [sspq_pkg::PRIO_W-1:0]    prio_q [sspq_pkg::QUEUE_DEPTH];
	logic [sspq_pkg::ID_W-1:0]      id_q   [sspq_pkg::QUEUE_DEPTH];
	logic [sspq_pkg::PAYLOAD_W-1:0] pay_q  [sspq_pkg::QUEUE_DEPTH];

	logic [sspq_pkg::CNT_W-1:0]     count_q;
	logic [sspq_pkg::ID_W-1:0]      id_ctr_q;

	logic                           act_q;
	logic [sspq_pkg::PRIO_W-1:0]    req_prio_q;
	logic [sspq_pkg::PAYLOAD_W-1:0] req_pay_q;

	logic [sspq_pkg::QUEUE_DEPTH-1:0] ge;
	logic [sspq_pkg::QUEUE_DEPTH-1:0] ge_prev;

	logic do_insert;
	logic do_remove;

	assign do_insert = cmd.exec && (cmd.op == sspq_pkg::OP_INSERT);
	assign do_remove = cmd.exec && (cmd.op == sspq_pkg::OP_REMOVE);

	// Each occupied cell compares its priority with the request
	always_comb begin
		for (int i = 0; i < sspq_pkg::QUEUE_DEPTH; i++) begin
			ge[i] = (sspq_pkg::CNT_W'(i) < count_q) && (prio_q[i] >= req_prio_q);
		end
	end

	// The cell below the insert point sees its upper neighbor stay put
	assign ge_prev = {ge[sspq_pkg::QUEUE_DEPTH-2:0], 1'b1};

	// Report request and fill state to the controller
	assign stat.is_remove = (act_q == sspq_pkg::ACT_REMOVE);
	assign stat.prio_ok   = (req_prio_q >= sspq_pkg::PRIO_MIN) &&
		(req_prio_q <= sspq_pkg::PRIO_MAX);
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == sspq_pkg::CNT_W'(sspq_pkg::QUEUE_DEPTH));

	// Latch the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (cmd.load) begin
			act_q <= req_action;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_prio_q <= req_priority;
			req_pay_q  <= req_payload;
		end
	end

	// Cells: keep, take the new entry, or shift from a neighbor
	for (genvar i = 0; i < sspq_pkg::QUEUE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_insert && !ge[i]) begin
					prio_q[i] <= req_prio_q;
					id_q[i]   <= id_ctr_q;
					pay_q[i]  <= req_pay_q;
				end else if (do_remove) begin
					prio_q[i] <= prio_q[i+1];
					id_q[i]   <= id_q[i+1];
					pay_q[i]  <= pay_q[i+1];
				end
			end
		end else if (i == sspq_pkg::QUEUE_DEPTH - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (do_insert && !ge[i]) begin
					if (ge_prev[i]) begin
						prio_q[i] <= req_prio_q;
						id_q[i]   <= id_ctr_q;
						pay_q[i]  <= req_pay_q;
					end else begin
						prio_q[i] <= prio_q[i-1];
						id_q[i]   <= id_q[i-1];
						pay_q[i]  <= pay_q[i-1];
					end
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (do_insert && !ge[i]) begin
					if (ge_prev[i]) begin
						prio_q[i] <= req_prio_q;
						id_q[i]   <= id_ctr_q;
						pay_q[i]  <= req_pay_q;
					end else begin
						prio_q[i] <= prio_q[i-1];
						id_q[i]   <= id_q[i-1];
						pay_q[i]  <= pay_q[i-1];
					end
				end else if (do_remove) begin
					prio_q[i] <= prio_q[i+1];
					id_q[i]   <= id_q[i+1];
					pay_q[i]  <= pay_q[i+1];
				end
			end
		end
	end

	// Advance the fill count and the id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			id_ctr_q <= sspq_pkg::ID_FIRST;
		end else if (do_insert) begin
			count_q  <= count_q + 1'b1;
			id_ctr_q <= id_ctr_q + 1'b1;
		end else if (do_remove) begin
			count_q  <= count_q - 1'b1;
		end
	end

	// Capture the result of the operation
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status <= cmd.code;
			case (cmd.op)
				sspq_pkg::OP_INSERT: begin
					res_id        <= id_ctr_q;
					res_priority  <= '0;
					res_payload   <= '0;
					res_occupancy <= sspq_pkg::OCC_W'(count_q + 1'b1);
				end
				sspq_pkg::OP_REMOVE: begin
					res_id        <= id_q[0];
					res_priority  <= prio_q[0];
					res_payload   <= pay_q[0];
					res_occupancy <= sspq_pkg::OCC_W'(count_q - 1'b1);
				end
				default: begin
					res_id        <= '0;
					res_priority  <= '0;
					res_payload   <= '0;
					res_occupancy <= sspq_pkg::OCC_W'(count_q);
				end
			endcase
		end
	end

endmodule

>>> rtl/sspq_ctrl.sv
// Controller: request/response handshakes and operation decode.
module sspq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  sspq_pkg::stat_t stat,
	output sspq_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   fire;

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	// Fire once the result register is free or being emptied
	assign fire = (state_q == S_EXEC) && (!out_valid_q || rsp_ready);

	// Decode the latched request into an operation and a status code
	always_comb begin
		cmd.load = cmd_valid && cmd_ready;
		cmd.exec = fire;
		cmd.op   = sspq_pkg::OP_NONE;
		cmd.code = sspq_pkg::ST_OK;
		if (stat.is_remove) begin
			if (stat.empty) begin
				cmd.code = sspq_pkg::ST_EMPTY;
			end else begin
				cmd.op = sspq_pkg::OP_REMOVE;
			end
		end else if (!stat.prio_ok) begin
			cmd.code = sspq_pkg::ST_RANGE;
		end else if (stat.full) begin
			cmd.code = sspq_pkg::ST_FULL;
		end else begin
			cmd.op = sspq_pkg::OP_INSERT;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and the response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/stable_sorted_priority_queue.sv
// A request accepted into the request latch is evaluated in the execute state; its response is
// registered once the result register is free or being emptied.
// The request latch feeds the cell array compare and shift, which updates the 16 cells and the
// response register together; the next request is accepted once the current one has executed.
// A pending response does not block the next request; a stalled response holds the engine.
// Reset: asynchronous, clears the entry count to zero and sets the id counter to one.
// Cell contents are not cleared; only occupied cells are ever read.
module stable_sorted_priority_queue (
	input logic         clk,
	input logic         arst_n,
	sspq_cmd_if.sink    cmd,
	sspq_rsp_if.source  rsp
);

	sspq_pkg::cmd_t  dp_cmd;
	sspq_pkg::stat_t dp_stat;

	// Sequence handshakes and decode operations
	sspq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// Hold the sorted entries and build responses
	sspq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.req_action    (cmd.action),
		.req_priority  (cmd.priority_req),
		.req_payload   (cmd.payload),
		.res_status    (rsp.status),
		.res_id        (rsp.entry_id),
		.res_priority  (rsp.entry_priority),
		.res_payload   (rsp.entry_payload),
		.res_occupancy (rsp.occupancy)
	);

endmodule

>>> rtl/sspq_checker.sv
// Port-level checker for the priority queue, bound to the top level.
`include "stable_sorted_priority_queue_defines.svh"

module sspq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [1:0]                       rsp_status,
	input logic [sspq_pkg::ID_W-1:0]        rsp_entry_id,
	input logic [sspq_pkg::PRIO_W-1:0]      rsp_entry_priority,
	input logic [sspq_pkg::OCC_W-1:0]       rsp_occupancy
);

	`SSPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
	`SSPQ_ASSERT_SAME(a_empty_occ, rsp_valid && (rsp_status == sspq_pkg::ST_EMPTY), rsp_occupancy == '0, "empty status with entries stored")
	`SSPQ_ASSERT_SAME(a_full_occ, rsp_valid && (rsp_status == sspq_pkg::ST_FULL), rsp_occupancy == sspq_pkg::OCC_W'(sspq_pkg::QUEUE_DEPTH), "full status below capacity")
	`SSPQ_ASSERT_SAME(a_reject_zero, rsp_valid && (rsp_status != sspq_pkg::ST_OK), (rsp_entry_id == '0) && (rsp_entry_priority == '0), "rejected transaction carries an entry")
	`SSPQ_ASSERT_SAME(a_occ_bound, rsp_valid, rsp_occupancy <= sspq_pkg::OCC_W'(sspq_pkg::QUEUE_DEPTH), "occupancy above capacity")

endmodule

bind stable_sorted_priority_queue sspq_checker u_sspq_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_entry_id       (rsp.entry_id),
	.rsp_entry_priority (rsp.entry_priority),
	.rsp_occupancy      (rsp.occupancy)
);

>>> tb/tb_top.sv
// Self-checking bench for the stable sorted priority queue, built around a queue model.
module tb_top;
	import sspq_pkg::*;

	localparam int          WATCHDOG_LIMIT   = 2000;
	localparam int          LONG_HOLD_CYCLES = 64;
	localparam int          PRESSURE_ITEMS   = 40;
	localparam int          RANDOM_ITEMS     = 1250;
	localparam int          MIX_CHUNK        = 60;
	localparam int          SETTLE_CYCLES    = 8;
	localparam int          MAX_REPORTS      = 10;

	typedef enum {RDY_RUN, RDY_STALL, RDY_CHOPPY, RDY_TOGGLE} ready_mode_t;

	typedef struct {
		status_t                status;
		logic [ID_W-1:0]        id;
		logic [PRIO_W-1:0]      prio;
		logic [PAYLOAD_W-1:0]   payload;
		logic [OCC_W-1:0]       occupancy;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n;

	sspq_cmd_if cmd_ch ();
	sspq_rsp_if rsp_ch ();

	stable_sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Model state: sorted slots, slot 0 leaves next
	logic [PRIO_W-1:0]    held_prio [QUEUE_DEPTH];
	logic [ID_W-1:0]      held_id [QUEUE_DEPTH];
	logic [PAYLOAD_W-1:0] held_payload [QUEUE_DEPTH];
	int                   held_count = 0;
	logic [ID_W-1:0]      next_id = ID_FIRST;

	queue_result_t outcomes_due[$];
	int            error_count = 0;
	int            replies_seen = 0;
	int            idle_cycles = 0;
	int            burst_left = 0;
	bit            hold_replies = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one operation to the model queue and return the response it must produce
	function automatic queue_result_t queue_op_outcome(action_t act, logic [PRIO_W-1:0] prio,
			logic [PAYLOAD_W-1:0] pl);
		queue_result_t r;
		int pos;
		int i;
		r = '{status: ST_OK, id: '0, prio: '0, payload: '0, occupancy: '0};
		if (act == ACT_INSERT) begin
			if (prio < PRIO_MIN || prio > PRIO_MAX) begin
				r.status = ST_RANGE;
			end else if (held_count >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// place after every entry of equal or higher priority
				pos = 0;
				while (pos < held_count && held_prio[pos] >= prio) pos++;
				for (i = held_count; i > pos; i--) begin
					held_prio[i]    = held_prio[i-1];
					held_id[i]      = held_id[i-1];
					held_payload[i] = held_payload[i-1];
				end
				held_prio[pos]    = prio;
				held_id[pos]      = next_id;
				held_payload[pos] = pl;
				held_count++;
				r.id = next_id;
				next_id = next_id + 1'b1;
			end
		end else if (held_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			// pop the head and shift the rest up
			r.id      = held_id[0];
			r.prio    = held_prio[0];
			r.payload = held_payload[0];
			for (i = 1; i < held_count; i++) begin
				held_prio[i-1]    = held_prio[i];
				held_id[i-1]      = held_id[i];
				held_payload[i-1] = held_payload[i];
			end
			held_count--;
		end
		r.occupancy = OCC_W'(held_count);
		return r;
	endfunction

	// Priority mix: mostly legal, clustered at both ends for ties, some out of range
	function automatic logic [PRIO_W-1:0] pick_priority();
		case ($urandom_range(0, 9))
			0: begin
				if ($urandom_range(0, 3) == 0) return '0;
				return PRIO_W'($urandom_range(int'(PRIO_MAX) + 1, (1 << PRIO_W) - 1));
			end
			1: return PRIO_W'($urandom_range(PRIO_MIN, PRIO_MIN + 2));
			2: return PRIO_W'($urandom_range(PRIO_MAX - 2, PRIO_MAX));
			default: return PRIO_W'($urandom_range(PRIO_MIN, PRIO_MAX));
		endcase
	endfunction

	// Offer one transaction, hold it until accepted, then record its outcome
	task automatic send_op(action_t act, logic [PRIO_W-1:0] prio, logic [PAYLOAD_W-1:0] pl);
		cmd_ch.valid        <= 1'b1;
		cmd_ch.action       <= act;
		cmd_ch.priority_req <= prio;
		cmd_ch.payload      <= pl;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		outcomes_due.push_back(queue_op_outcome(act, prio, pl));
	endtask

	task automatic idle_sender(int cycles);
		cmd_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// End a burst now and then with a random gap
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
		end
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_remove_empty();
		send_op(ACT_REMOVE, '1, '1);
		pace();
	endtask

	task automatic test_priority_range();
		send_op(ACT_INSERT, '0, '1);
		pace();
		send_op(ACT_INSERT, '1, '0);
		pace();
		send_op(ACT_INSERT, PRIO_MAX + 1'b1, 32'h1234_5678);
		pace();
		send_op(ACT_INSERT, PRIO_MAX, '1);
		pace();
		send_op(ACT_INSERT, PRIO_MIN, '0);
		pace();
		send_op(ACT_INSERT, PRIO_MAX + 1'b1, '1);
		pace();
	endtask

	// Equal priorities must leave in arrival order, behind the higher one
	task automatic test_equal_priority_order();
		send_op(ACT_INSERT, PRIO_MAX / 2, 32'h0000_0001);
		pace();
		send_op(ACT_INSERT, PRIO_MAX / 2, 32'h0000_0002);
		pace();
		send_op(ACT_INSERT, PRIO_MAX / 2, 32'h0000_0003);
		pace();
		repeat (6) begin
			send_op(ACT_REMOVE, '0, '0);
			pace();
		end
	endtask

	task automatic test_fill_to_full();
		while (held_count < QUEUE_DEPTH) begin
			send_op(ACT_INSERT, PRIO_W'($urandom_range(PRIO_MIN, PRIO_MAX)), $urandom());
			pace();
		end
		// full queue: range check still wins over the full check
		send_op(ACT_INSERT, PRIO_MAX, $urandom());
		pace();
		send_op(ACT_INSERT, '0, $urandom());
		pace();
		send_op(ACT_INSERT, '1, $urandom());
		pace();
		while (held_count > 0) begin
			send_op(ACT_REMOVE, pick_priority(), $urandom());
			pace();
		end
		send_op(ACT_REMOVE, '0, '0);
		pace();
	endtask

	// Hold off the response side while the sender keeps offering
	task automatic test_backpressure();
		hold_replies = 1'b1;
		repeat (PRESSURE_ITEMS) begin
			send_op(action_t'($urandom_range(0, 3) == 0), pick_priority(), $urandom());
		end
	endtask

	task automatic test_random_mix();
		int n;
		int insert_pct;
		action_t act;
		insert_pct = 50;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// swing the insert share so the queue reaches both full and empty
			if (n % MIX_CHUNK == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 15;
					1: insert_pct = 50;
					default: insert_pct = 85;
				endcase
			end
			act = ($urandom_range(1, 100) <= insert_pct) ? ACT_INSERT : ACT_REMOVE;
			send_op(act, pick_priority(), $urandom());
			pace();
		end
	endtask

	// Response ready: runs of ready, stalls, random and toggling, plus the long hold
	initial begin : reply_ready_driver
		ready_mode_t mode;
		int run_len;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_replies) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_replies = 1'b0;
			end else begin
				mode    = ready_mode_t'($urandom_range(0, 3));
				run_len = $urandom_range(1, 16);
				case (mode)
					RDY_RUN: begin
						rsp_ch.ready <= 1'b1;
						repeat (run_len) @(posedge clk);
					end
					RDY_STALL: begin
						rsp_ch.ready <= 1'b0;
						repeat ($urandom_range(1, 6)) @(posedge clk);
					end
					RDY_CHOPPY: repeat (run_len) begin
						rsp_ch.ready <= 1'($urandom_range(0, 1));
						@(posedge clk);
					end
					default: repeat (run_len) begin
						rsp_ch.ready <= ~rsp_ch.ready;
						@(posedge clk);
					end
				endcase
			end
		end
	end

	// Compare each accepted response with the oldest outstanding outcome
	always @(posedge clk) begin : check_replies
		queue_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			replies_seen++;
			if (outcomes_due.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("MISMATCH response %0d: nothing outstanding", replies_seen);
				error_count++;
			end else begin
				want = outcomes_due.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.entry_id !== want.id ||
						rsp_ch.entry_priority !== want.prio ||
						rsp_ch.entry_payload !== want.payload ||
						rsp_ch.occupancy !== want.occupancy) begin
					if (error_count < MAX_REPORTS) begin
						$display("MISMATCH response %0d: expected st %0d id %0d pri %0d pl %h occ %0d",
							replies_seen, want.status, want.id, want.prio, want.payload,
							want.occupancy);
						$display("  got st %0d id %0d pri %0d pl %h occ %0d",
							rsp_ch.status, rsp_ch.entry_id, rsp_ch.entry_priority,
							rsp_ch.entry_payload, rsp_ch.occupancy);
					end
					error_count++;
				end
			end
		end
	end

	// Stop a hung run: count cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		cmd_ch.valid        = 1'b0;
		cmd_ch.action       = ACT_INSERT;
		cmd_ch.priority_req = '0;
		cmd_ch.payload      = '0;
		arst_n              = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_remove_empty();
		test_priority_range();
		test_equal_priority_order();
		test_fill_to_full();
		wait_drained();
		test_backpressure();
		wait_drained();
		test_random_mix();
		wait_drained();

		// let any stray response show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && outcomes_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/sspq_pkg.sv
rtl/sspq_channels.sv
rtl/sspq_dp.sv
rtl/sspq_ctrl.sv
rtl/stable_sorted_priority_queue.sv
rtl/sspq_checker.sv
tb/tb_top.sv
